### sv/fpsa_pkg.sv
package fpsa_pkg;

  localparam int unsigned MaxSegmentsDef = 32;
  localparam int unsigned PoolSizeDef    = 65536;

  localparam int unsigned SizeW = 17;
  localparam int unsigned OffW  = 16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POL_NONE  = 2'd0,
    POL_FIRST = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_e;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PEEK,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic              action;
    logic [SizeW-1:0]  request_size;
    logic [OffW-1:0]   free_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [OffW-1:0]   block_offset;
    logic [SizeW-1:0]  block_size;
  } rsp_t;

  typedef struct packed {
    logic              used;
    logic [SizeW-1:0]  len;
    logic [OffW-1:0]   start;
  } seg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic peek;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;
    logic need_peek;
  } sts_t;

  localparam int unsigned CfgFitPolicy = 0;

endpackage

### sv/fpsa_ctrl.sv
module fpsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  fpsa_pkg::sts_t sts_i,
  output fpsa_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import fpsa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_end) state_d = sts_i.need_peek ? S_PEEK : S_COMMIT;
      end
      S_PEEK:   state_d = S_COMMIT;
      S_COMMIT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:   cmd_o.load = start_i;
      S_SCAN:   cmd_o.scan = 1'b1;
      S_PEEK:   cmd_o.peek = 1'b1;
      S_COMMIT: cmd_o.commit = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### sv/fpsa_dp.sv
module fpsa_dp #(
  parameter int unsigned MaxSegments = fpsa_pkg::MaxSegmentsDef,
  parameter int unsigned PoolSize    = fpsa_pkg::PoolSizeDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fpsa_pkg::cmd_t cmd_i,
  input  fpsa_pkg::req_t req_i,
  input  logic [1:0]     policy_i,
  output fpsa_pkg::sts_t sts_o,
  output logic           done_o,
  output fpsa_pkg::rsp_t rsp_o
);
  import fpsa_pkg::*;

  localparam int unsigned IW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int unsigned CW = $clog2(MaxSegments + 1);

  seg_t tbl_q [MaxSegments];
  seg_t tbl_d [MaxSegments];

  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q;
  req_t             req_q;
  logic             found_q;
  logic [CW-1:0]    pick_q;
  logic [SizeW-1:0] best_q;
  logic [OffW-1:0]  pick_start_q;
  logic             prev_used_q;
  logic [SizeW-1:0] prev_len_q;
  logic [OffW-1:0]  prev_start_q;
  logic             next_free_q;
  logic [SizeW-1:0] next_len_q;
  logic             done_q;
  rsp_t             rsp_q, rsp_d;

  seg_t cur;
  logic is_free, fits, upd, hit, last;

  assign cur     = tbl_q[idx_q[IW-1:0]];
  assign is_free = (req_q.action == ACT_FREE);
  assign fits    = !cur.used && (cur.len >= req_q.request_size) && (req_q.request_size != '0);
  assign last    = (idx_q == count_q - CW'(1));
  assign hit     = is_free && !found_q && cur.used && (cur.start == req_q.free_offset);

  always_comb begin
    upd = 1'b0;
    case (policy_i)
      POL_FIRST: upd = fits && !found_q;
      POL_BEST:  upd = fits && (!found_q || cur.len < best_q);
      POL_WORST: upd = fits && (cur.len > best_q);
      default:   upd = 1'b0;
    endcase
    if (is_free) upd = 1'b0;
  end

  assign sts_o.scan_end  = last || hit || (!is_free && policy_i == POL_FIRST && fits);
  assign sts_o.need_peek = hit;

  // scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + CW'(1);
      if (upd || hit) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q       <= req_i;
      best_q      <= '0;
      prev_used_q <= 1'b1;
      next_free_q <= 1'b0;
    end else if (cmd_i.scan) begin
      if (upd || hit) begin
        pick_q       <= idx_q;
        best_q       <= cur.len;
        pick_start_q <= cur.start;
      end else if (is_free && !found_q) begin
        prev_used_q  <= cur.used;
        prev_len_q   <= cur.len;
        prev_start_q <= cur.start;
      end
    end else if (cmd_i.peek) begin
      next_free_q <= (idx_q < count_q) && !cur.used;
      next_len_q  <= cur.len;
    end
  end

  // commit decisions
  logic             split, pm, nm, do_split, do_mark, do_free;
  logic [SizeW-1:0] sum2p, sum2n, sum3;

  assign split    = best_q > req_q.request_size;
  assign pm       = !prev_used_q;
  assign nm       = next_free_q;
  assign sum2p    = prev_len_q + best_q;
  assign sum2n    = best_q + next_len_q;
  assign sum3     = SizeW'(prev_len_q + best_q + next_len_q);
  assign do_split = cmd_i.commit && !is_free && found_q && split
                    && (count_q < CW'(MaxSegments));
  assign do_mark  = cmd_i.commit && !is_free && found_q && !split;
  assign do_free  = cmd_i.commit && is_free && found_q;

  always_comb begin
    rsp_d   = '0;
    count_d = count_q;
    if (!is_free) begin
      if (!found_q) begin
        rsp_d.status = ST_NO_FIT;
      end else if (split && count_q >= CW'(MaxSegments)) begin
        rsp_d.status = ST_FULL;
      end else begin
        rsp_d.status       = ST_OK;
        rsp_d.block_offset = pick_start_q;
        rsp_d.block_size   = split ? req_q.request_size : best_q;
        if (split) count_d = count_q + CW'(1);
      end
    end else if (!found_q) begin
      rsp_d.status = ST_NOT_ALLOC;
    end else begin
      rsp_d.status       = ST_OK;
      rsp_d.block_offset = pm ? prev_start_q : pick_start_q;
      if (pm && nm) begin
        rsp_d.block_size = sum3;
        count_d          = count_q - CW'(2);
      end else if (pm) begin
        rsp_d.block_size = sum2p;
        count_d          = count_q - CW'(1);
      end else if (nm) begin
        rsp_d.block_size = sum2n;
        count_d          = count_q - CW'(1);
      end else begin
        rsp_d.block_size = best_q;
      end
    end
  end

  // per entry update, each entry sees only itself, its previous entry and the next two
  for (genvar j = 0; j < MaxSegments; j++) begin : g_ent
    localparam int unsigned JP1 = (j + 1 < MaxSegments) ? j + 1 : j;
    localparam int unsigned JP2 = (j + 2 < MaxSegments) ? j + 2 : j;
    localparam int unsigned JM1 = (j > 0) ? j - 1 : j;
    logic [CW:0] jj;
    assign jj = (CW+1)'(j);

    always_comb begin
      tbl_d[j] = tbl_q[j];
      if (do_mark && jj == {1'b0, pick_q}) begin
        tbl_d[j].used = 1'b1;
      end else if (do_split) begin
        if (jj == {1'b0, pick_q}) begin
          tbl_d[j].len  = req_q.request_size;
          tbl_d[j].used = 1'b1;
        end else if (jj == {1'b0, pick_q} + (CW+1)'(1)) begin
          tbl_d[j].start = OffW'(pick_start_q + req_q.request_size[OffW-1:0]);
          tbl_d[j].len   = SizeW'(best_q - req_q.request_size);
          tbl_d[j].used  = 1'b0;
        end else if (jj > {1'b0, pick_q} + (CW+1)'(1)) begin
          tbl_d[j] = tbl_q[JM1];
        end
      end else if (do_free) begin
        if (pm && nm) begin
          if (jj + (CW+1)'(1) == {1'b0, pick_q}) tbl_d[j].len = sum3;
          else if (jj >= {1'b0, pick_q}) tbl_d[j] = tbl_q[JP2];
        end else if (pm) begin
          if (jj + (CW+1)'(1) == {1'b0, pick_q}) tbl_d[j].len = sum2p;
          else if (jj >= {1'b0, pick_q}) tbl_d[j] = tbl_q[JP1];
        end else if (nm) begin
          if (jj == {1'b0, pick_q}) begin
            tbl_d[j].len  = sum2n;
            tbl_d[j].used = 1'b0;
          end else if (jj > {1'b0, pick_q}) begin
            tbl_d[j] = tbl_q[JP1];
          end
        end else if (jj == {1'b0, pick_q}) begin
          tbl_d[j].used = 1'b0;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tbl_q[j].used  <= 1'b0;
        tbl_q[j].start <= '0;
        tbl_q[j].len   <= (j == 0) ? SizeW'(PoolSize) : '0;
      end else begin
        tbl_q[j] <= tbl_d[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CW'(1);
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
      if (cmd_i.commit) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### sv/fit_policy_segment_allocator.sv
// channel   | signals                              | transaction
// ----------+--------------------------------------+----------------------------------
// request   | start, busy, req_i                   | edge with start high, busy low
// result    | done_o, rsp_o                        | one cycle with done_o high
// config    | psel penable pwrite paddr pwdata ... | apb access, fit_policy at 0x0
//
// an item runs through a scan over the table entries, one entry at a time
// (first fit and free stop at the hit), a peek when a free finds its block,
// a commit, then the result cycle
// the table update (split or merge) is a single parallel shift in the commit cycle
// reset restores one free segment covering the pool and fit_policy to first fit
// busy stays high from accept until the result cycle; results cannot be stalled
module fit_policy_segment_allocator #(
  parameter int unsigned MaxSegments = fpsa_pkg::MaxSegmentsDef,
  parameter int unsigned PoolSize    = fpsa_pkg::PoolSizeDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // request side
  input  logic           start,
  output logic           busy,
  input  fpsa_pkg::req_t req_i,
  // result side
  output logic           done_o,
  output fpsa_pkg::rsp_t rsp_o,
  // apb config
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import fpsa_pkg::*;

  logic [1:0] fit_policy_q;
  cmd_t       cmd;
  sts_t       sts;
  logic       cfg_hit;

  // only register 0 exists; other addresses read zero and ignore writes
  assign cfg_hit = (paddr == 3'(CfgFitPolicy * 4));
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? {30'b0, fit_policy_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q <= POL_FIRST;
    end else if (psel && penable && pwrite && cfg_hit) begin
      fit_policy_q <= pwdata[1:0];
    end
  end

  // sequencing: load, scan, optional peek, commit
  fpsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // segment table, scan registers and result register
  fpsa_dp #(
    .MaxSegments(MaxSegments),
    .PoolSize   (PoolSize)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .req_i   (req_i),
    .policy_i(fit_policy_q),
    .sts_o   (sts),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule

### sv/fpsa_checker.sv
module fpsa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input fpsa_pkg::rsp_t rsp_o,
  input logic           pready
);
  import fpsa_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");

  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("busy dropped without a result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy)) else $error("result outside end of work");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ST_OK |-> rsp_o.block_offset == '0 && rsp_o.block_size == '0)
    else $error("error result carries data");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready) else $error("pready low");

endmodule

bind fit_policy_segment_allocator fpsa_checker u_fpsa_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o),
  .pready(pready)
);

### tb/tb_fit_policy_segment_allocator.sv
module tb_fit_policy_segment_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import fpsa_pkg::*;

  localparam int unsigned NumSegs  = 32;
  localparam int unsigned PoolUnits = 65536;
  localparam int unsigned WatchLimit = 20000;

  // allocator state mirror plus a queue of expected responses
  class alloc_tracker;
    logic [OffW-1:0]  seg_start [NumSegs];
    logic [SizeW-1:0] seg_len   [NumSegs];
    bit               seg_used  [NumSegs];
    int unsigned      seg_count;
    policy_e          policy;
    rsp_t             pending [$];
    int unsigned      mismatches;

    function new();
      for (int i = 0; i < NumSegs; i++) begin
        seg_start[i] = '0;
        seg_len[i]   = '0;
        seg_used[i]  = 1'b0;
      end
      seg_len[0] = SizeW'(PoolUnits);
      seg_count  = 1;
      policy     = POL_FIRST;
      mismatches = 0;
    endfunction

    function void remove_at(int unsigned idx);
      for (int unsigned j = idx; j + 1 < seg_count; j++) begin
        seg_start[j] = seg_start[j+1];
        seg_len[j]   = seg_len[j+1];
        seg_used[j]  = seg_used[j+1];
      end
      seg_count--;
    endfunction

    function rsp_t grant(logic [SizeW-1:0] sz);
      rsp_t r;
      bit found;
      int unsigned pick;
      logic [SizeW-1:0] best;
      r = '0;
      found = 0;
      pick = 0;
      best = '0;
      r.status = ST_NO_FIT;
      if (sz == 0) return r;
      for (int unsigned i = 0; i < seg_count; i++) begin
        if (seg_used[i] || seg_len[i] < sz) continue;
        if (policy == POL_FIRST) begin
          pick = i; found = 1;
          break;
        end else if (policy == POL_BEST) begin
          if (!found || seg_len[i] < best) begin
            pick = i; best = seg_len[i]; found = 1;
          end
        end else if (policy == POL_WORST) begin
          if (seg_len[i] > best) begin
            pick = i; best = seg_len[i]; found = 1;
          end
        end
      end
      if (!found) return r;
      if (seg_len[pick] > sz) begin
        if (seg_count >= NumSegs) begin
          r.status = ST_FULL;
          return r;
        end
        // open a hole after the pick for the leftover free piece
        for (int unsigned j = seg_count; j > pick + 1; j--) begin
          seg_start[j] = seg_start[j-1];
          seg_len[j]   = seg_len[j-1];
          seg_used[j]  = seg_used[j-1];
        end
        seg_start[pick+1] = OffW'(seg_start[pick] + sz);
        seg_len[pick+1]   = seg_len[pick] - sz;
        seg_used[pick+1]  = 1'b0;
        seg_count++;
        seg_len[pick] = sz;
      end
      seg_used[pick] = 1'b1;
      r.status = ST_OK;
      r.block_offset = seg_start[pick];
      r.block_size = seg_len[pick];
      return r;
    endfunction

    function rsp_t release_block(logic [OffW-1:0] off);
      rsp_t r;
      bit found;
      int unsigned k;
      r = '0;
      found = 0;
      k = 0;
      for (int unsigned i = 0; i < seg_count; i++) begin
        if (seg_used[i] && seg_start[i] == off) begin
          k = i; found = 1;
          break;
        end
      end
      if (!found) begin
        r.status = ST_NOT_ALLOC;
        return r;
      end
      seg_used[k] = 1'b0;
      if (k > 0 && !seg_used[k-1]) begin
        seg_len[k-1] = seg_len[k-1] + seg_len[k];
        remove_at(k);
        k--;
      end
      if (k + 1 < seg_count && !seg_used[k+1]) begin
        seg_len[k] = seg_len[k] + seg_len[k+1];
        remove_at(k + 1);
      end
      r.status = ST_OK;
      r.block_offset = seg_start[k];
      r.block_size = seg_len[k];
      return r;
    endfunction

    function void note_request(req_t q);
      if (q.action == ACT_ALLOC) pending.push_back(grant(q.request_size));
      else pending.push_back(release_block(q.free_offset));
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.block_offset !== exp.block_offset ||
          got.block_size !== exp.block_size) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response mismatch: exp st=%0d off=%0d sz=%0d got st=%0d off=%0d sz=%0d",
                   exp.status, exp.block_offset, exp.block_size,
                   got.status, got.block_offset, got.block_size);
      end
    endfunction

    // pick a start offset of a used block, or any offset when none
    function logic [OffW-1:0] some_used_start();
      int unsigned idx [$];
      for (int unsigned i = 0; i < seg_count; i++)
        if (seg_used[i]) idx.push_back(i);
      if (idx.size() == 0) return OffW'($urandom);
      return seg_start[idx[$urandom_range(idx.size() - 1)]];
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  alloc_tracker tracker;
  int unsigned idle_cycles;
  int unsigned accepted;

  fit_policy_segment_allocator dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .rsp_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // response monitor and no-progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) tracker.check_response(rsp_o);
      if (done_o || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("tb_fit_policy_segment_allocator failed");
        $finish;
      end
    end
  end

  // one transaction, held until the block accepts it
  task automatic send_request(action_e act, logic [SizeW-1:0] sz, logic [OffW-1:0] off);
    req_t q;
    q.action = act;
    q.request_size = sz;
    q.free_offset = off;
    start <= 1'b1;
    req_i <= q;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    tracker.note_request(q);
    accepted++;
  endtask

  task automatic hold_idle(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write while the block is idle
  task automatic write_policy(logic [1:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * CfgFitPolicy); pwdata <= {30'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.policy = policy_e'(val);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // random sizes, mostly small so the table fills and splits often
  function automatic logic [SizeW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return SizeW'($urandom_range(1, 4096));
    if (r < 85) return SizeW'($urandom_range(1, 64));
    if (r < 95) return SizeW'($urandom_range(0, 65536));
    return SizeW'($urandom_range(65535, 131071));
  endfunction

  task automatic random_phase(int unsigned n);
    int unsigned burst;
    int unsigned sent;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 20);
      for (int unsigned b = 0; b < burst && sent < n; b++) begin
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) send_request(ACT_ALLOC, pick_size(), OffW'($urandom));
        else if (r < 90) send_request(ACT_FREE, SizeW'($urandom), tracker.some_used_start());
        else send_request(ACT_FREE, SizeW'($urandom), OffW'($urandom));
        sent++;
      end
      if ($urandom_range(3) != 0) hold_idle($urandom_range(1, 50));
    end
  endtask

  initial begin
    tracker = new();
    idle_cycles = 0;
    accepted = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero size, whole pool, oversize, bogus frees, policy none
    send_request(ACT_ALLOC, '0, 16'hFFFF);
    send_request(ACT_ALLOC, SizeW'(131071), '0);
    send_request(ACT_ALLOC, SizeW'(PoolUnits), '0);
    send_request(ACT_ALLOC, SizeW'(1), '0);
    send_request(ACT_FREE, SizeW'(131071), '0);
    send_request(ACT_FREE, '0, 16'hFFFF);
    send_request(ACT_ALLOC, SizeW'(100), '0);
    send_request(ACT_ALLOC, SizeW'(200), '0);
    send_request(ACT_ALLOC, SizeW'(50), '0);
    send_request(ACT_FREE, '0, 16'd100);
    send_request(ACT_FREE, '0, 16'd100);
    send_request(ACT_ALLOC, SizeW'(65535), '0);
    send_request(ACT_FREE, '0, 16'd0);
    send_request(ACT_FREE, '0, 16'd300);
    send_request(ACT_ALLOC, SizeW'(20), '0);
    wait_drained();
    write_policy(POL_NONE);
    send_request(ACT_ALLOC, SizeW'(1), '0);
    // table-full: 34 single-unit allocations fill the table, then 34 frees
    wait_drained();
    write_policy(POL_FIRST);
    for (int i = 0; i < 34; i++) send_request(ACT_ALLOC, SizeW'(1), '0);
    for (int i = 0; i < 34; i++) send_request(ACT_FREE, '0, tracker.some_used_start());
    wait_drained();

    // random phases through every policy
    write_policy(POL_BEST);
    random_phase(250);
    wait_drained();
    write_policy(POL_WORST);
    random_phase(250);
    wait_drained();
    write_policy(POL_FIRST);
    random_phase(250);
    wait_drained();
    write_policy(POL_NONE);
    random_phase(30);
    wait_drained();
    write_policy(POL_BEST);
    random_phase(200);

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("tb_fit_policy_segment_allocator passed");
    end else begin
      $display("tb_fit_policy_segment_allocator failed");
    end
    $finish;
  end
endmodule

### sim.f
sv/fpsa_pkg.sv
sv/fpsa_ctrl.sv
sv/fpsa_dp.sv
sv/fit_policy_segment_allocator.sv
sv/fpsa_checker.sv
tb/tb_fit_policy_segment_allocator.sv
